### sv/wri_pkg.sv
// ---------------------------------------------------------------------------
// Waypoint route interpolator package
// Shared constants, table entry layout and controller/datapath interfaces.
// ---------------------------------------------------------------------------
package wri_pkg;

   localparam int MAX_WAYPOINTS = 64;

   localparam int DUR_W  = 32;
   localparam int CNT_W  = 7;
   localparam int PROD_W = DUR_W + CNT_W;
   localparam int DIFF_W = 33;
   localparam int SUM_W  = 34;
   localparam int HDG_W  = 18;

   localparam int HALF_TURN = 18000;
   localparam int FULL_TURN = 36000;

   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_START  = 2'd1;
   localparam logic [1:0] OP_STOP   = 2'd2;
   localparam logic [1:0] OP_SAMPLE = 2'd3;

   localparam logic [0:0] REG_DURATION = 1'd0;
   localparam logic [0:0] REG_COUNT    = 1'd1;

   localparam logic [1:0] LANE_LAT = 2'd0;
   localparam logic [1:0] LANE_LNG = 2'd1;
   localparam logic [1:0] LANE_ALT = 2'd2;
   localparam logic [1:0] LANE_HDG = 2'd3;

   typedef struct packed {
      logic signed [30:0] lat;
      logic signed [31:0] lng;
      logic signed [23:0] alt;
      logic        [15:0] hdg;
   } entry_type;

   typedef struct packed {
      logic       mem_wr;
      logic       load_e;
      logic       use_zero;
      logic       div_load;
      logic       div_step;
      logic       rd_seg;
      logic       rd_next;
      logic       rd_last;
      logic       cap_p0;
      logic       lane_mul;
      logic       lane_acc;
      logic [1:0] lane_sel;
      logic       wrap;
      logic       out_load;
      logic       out_last;
   } cmd_type;

   typedef struct packed {
      logic count_ok;
      logic e_ge_d;
      logic div_done;
      logic wrap_done;
      logic out_free;
   } status_type;

endpackage

### sv/wri_dp.sv
// ---------------------------------------------------------------------------
// Waypoint route interpolator datapath
// Route table, configuration registers, bit-serial divider, shared
// multiplier lane, heading wrap and the result register.
// ---------------------------------------------------------------------------
module wri_dp import wri_pkg::*; #(
   parameter int FRAC_BITS     = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [5:0]          req_waypoint_index,
   input  logic signed [30:0]  req_lat_in,
   input  logic signed [31:0]  req_lng_in,
   input  logic signed [23:0]  req_alt_in,
   input  logic [15:0]         req_heading_in,
   input  logic [31:0]         req_elapsed_ms,
   input  logic                csr_we,
   input  logic [0:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic signed [30:0]  rsp_lat_out,
   output logic signed [31:0]  rsp_lng_out,
   output logic signed [23:0]  rsp_alt_out,
   output logic [15:0]         rsp_heading_out,
   output logic                rsp_at_end
);

   localparam int AW  = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
   localparam int QW  = PROD_W + FRAC_BITS;
   localparam int DCW = $clog2(QW + 1);
   localparam int PW  = DIFF_W + FRAC_BITS + 1;
   localparam logic signed [PW-1:0]    RND_HALF = PW'(1) << (FRAC_BITS - 1);
   localparam logic signed [HDG_W-1:0] TURN_S   = HDG_W'(FULL_TURN);
   localparam logic signed [16:0]      HALF_S   = 17'(HALF_TURN);
   localparam logic signed [16:0]      FULL_S   = 17'(FULL_TURN);

   logic [DUR_W-1:0]        dur_ff, dur_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [DUR_W-1:0]        e_ff;
   entry_type               mem [MAX_WAYPOINTS];
   entry_type               rdata_ff;
   entry_type               p0_ff;
   logic [QW-1:0]           dvd_ff;
   logic [DUR_W-1:0]        rem_ff;
   logic [DCW-1:0]          div_cnt_ff;
   logic signed [PW-1:0]    prod_ff;
   logic signed [30:0]      lat_ff;
   logic signed [31:0]      lng_ff;
   logic signed [23:0]      alt_ff;
   logic signed [HDG_W-1:0] hdg_ff;
   logic                    rsp_valid_ff;
   logic signed [30:0]      rsp_lat_ff;
   logic signed [31:0]      rsp_lng_ff;
   logic signed [23:0]      rsp_alt_ff;
   logic [15:0]             rsp_hdg_ff;
   logic                    rsp_end_ff;

   logic [CNT_W-1:0]        n_eff;
   logic [CNT_W-1:0]        segs;
   logic [PROD_W-1:0]       prod;
   logic [DUR_W:0]          trial;
   logic                    trial_ge;
   logic [FRAC_BITS-1:0]    q;
   logic [AW-1:0]           a_seg, a_next, a_last, rd_addr;
   logic                    rd_en;
   logic                    wr_ok;
   logic signed [16:0]      hd, hd_adj;
   logic signed [DIFF_W-1:0] diff;
   logic signed [SUM_W-1:0] base;
   logic signed [PW-1:0]    prod_full;
   logic signed [PW-1:0]    rsum;
   logic signed [SUM_W-1:0] rnd;
   logic signed [SUM_W-1:0] acc;
   logic                    out_free;

   assign n_eff    = (32'(cnt_ff) > MAX_WAYPOINTS) ? CNT_W'(MAX_WAYPOINTS) : cnt_ff;
   assign segs     = n_eff - CNT_W'(1);
   assign prod     = PROD_W'(e_ff) * PROD_W'(segs);
   assign trial    = {rem_ff, dvd_ff[QW-1]};
   assign trial_ge = trial >= {1'b0, dur_ff};
   assign q        = dvd_ff[FRAC_BITS-1:0];
   assign a_seg    = dvd_ff[FRAC_BITS +: AW];
   assign a_next   = a_seg + AW'(1);
   assign a_last   = AW'(segs);
   assign wr_ok    = cmd.mem_wr && (32'(req_waypoint_index) < MAX_WAYPOINTS);
   assign rd_en    = cmd.rd_seg || cmd.rd_next || cmd.rd_last;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (cmd.rd_last) begin
         rd_addr = a_last;
      end else if (cmd.rd_next) begin
         rd_addr = a_next;
      end else begin
         rd_addr = a_seg;
      end
   end

   always_comb begin
      dur_in = dur_ff;
      cnt_in = cnt_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_DURATION: dur_in = csr_wdata;
            REG_COUNT:    cnt_in = csr_wdata[CNT_W-1:0];
            default:      dur_in = dur_ff;
         endcase
      end
   end

   always_comb begin
      hd = $signed({1'b0, rdata_ff.hdg}) - $signed({1'b0, p0_ff.hdg});
      if (hd > HALF_S) begin
         hd_adj = hd - FULL_S;
      end else if (hd < -HALF_S) begin
         hd_adj = hd + FULL_S;
      end else begin
         hd_adj = hd;
      end
      case (cmd.lane_sel)
         LANE_LAT: begin
            diff = DIFF_W'(rdata_ff.lat) - DIFF_W'(p0_ff.lat);
            base = SUM_W'(p0_ff.lat);
         end
         LANE_LNG: begin
            diff = DIFF_W'(rdata_ff.lng) - DIFF_W'(p0_ff.lng);
            base = SUM_W'(p0_ff.lng);
         end
         LANE_ALT: begin
            diff = DIFF_W'(rdata_ff.alt) - DIFF_W'(p0_ff.alt);
            base = SUM_W'(p0_ff.alt);
         end
         default: begin
            diff = DIFF_W'(hd_adj);
            base = $signed({{(SUM_W-16){1'b0}}, p0_ff.hdg});
         end
      endcase
   end

   assign prod_full = PW'(diff) * PW'($signed({1'b0, q}));
   assign rsum      = prod_ff + RND_HALF;
   assign rnd       = SUM_W'(rsum >>> FRAC_BITS);
   assign acc       = base + rnd;

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[AW'(req_waypoint_index)] <= '{lat: req_lat_in, lng: req_lng_in,
                                           alt: req_alt_in, hdg: req_heading_in};
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dur_ff       <= DUR_W'(96000);
         cnt_ff       <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dur_ff <= dur_in;
         cnt_ff <= cnt_in;
         if (cmd.div_load) begin
            div_cnt_ff <= DCW'(QW);
         end else if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff - DCW'(1);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_e) begin
         e_ff <= cmd.use_zero ? '0 : req_elapsed_ms;
      end
      if (cmd.div_load) begin
         dvd_ff <= {prod, {FRAC_BITS{1'b0}}};
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[QW-2:0], trial_ge};
         rem_ff <= trial_ge ? DUR_W'(trial - {1'b0, dur_ff}) : trial[DUR_W-1:0];
      end
      if (cmd.cap_p0) begin
         p0_ff <= rdata_ff;
      end
      if (cmd.lane_mul) begin
         prod_ff <= prod_full;
      end
      if (cmd.lane_acc) begin
         case (cmd.lane_sel)
            LANE_LAT: lat_ff <= 31'(acc);
            LANE_LNG: lng_ff <= 32'(acc);
            LANE_ALT: alt_ff <= 24'(acc);
            default:  hdg_ff <= HDG_W'(acc);
         endcase
      end else if (cmd.wrap) begin
         hdg_ff <= (hdg_ff < 0) ? hdg_ff + TURN_S : hdg_ff - TURN_S;
      end
      if (cmd.out_load) begin
         if (cmd.out_last) begin
            rsp_lat_ff <= rdata_ff.lat;
            rsp_lng_ff <= rdata_ff.lng;
            rsp_alt_ff <= rdata_ff.alt;
            rsp_hdg_ff <= rdata_ff.hdg;
         end else begin
            rsp_lat_ff <= lat_ff;
            rsp_lng_ff <= lng_ff;
            rsp_alt_ff <= alt_ff;
            rsp_hdg_ff <= hdg_ff[15:0];
         end
         rsp_end_ff <= cmd.out_last;
      end
   end

   assign status.count_ok  = n_eff >= CNT_W'(2);
   assign status.e_ge_d    = e_ff >= dur_ff;
   assign status.div_done  = div_cnt_ff == '0;
   assign status.wrap_done = (hdg_ff >= 0) && (hdg_ff < TURN_S);
   assign status.out_free  = out_free;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_lat_out     = rsp_lat_ff;
   assign rsp_lng_out     = rsp_lng_ff;
   assign rsp_alt_out     = rsp_alt_ff;
   assign rsp_heading_out = rsp_hdg_ff;
   assign rsp_at_end      = rsp_end_ff;

   a_div_step_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> div_cnt_ff != '0)
      else $error("divider stepped past its last bit");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("result register overwritten while held");

   a_heading_wrapped: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && !cmd.out_last) |-> status.wrap_done)
      else $error("heading emitted outside its range");

endmodule

### sv/wri_ctrl.sv
// ---------------------------------------------------------------------------
// Waypoint route interpolator controller
// Decodes input transfers, holds the running flag and sequences the datapath.
// ---------------------------------------------------------------------------
module wri_ctrl import wri_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_opcode,
   input  logic       csr_we,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CHECK = 4'd1;
   localparam logic [3:0] ST_DIV   = 4'd2;
   localparam logic [3:0] ST_RD0   = 4'd3;
   localparam logic [3:0] ST_RD1   = 4'd4;
   localparam logic [3:0] ST_MUL   = 4'd5;
   localparam logic [3:0] ST_ACC   = 4'd6;
   localparam logic [3:0] ST_WRAP  = 4'd7;
   localparam logic [3:0] ST_EMIT  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [1:0] lane_ff, lane_in;
   logic       last_ff, last_in;
   logic       running_ff, running_in;
   logic       accept;

   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      lane_in    = lane_ff;
      last_in    = last_ff;
      running_in = running_ff;
      cmd          = '0;
      cmd.lane_sel = lane_ff;
      cmd.out_last = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_opcode)
                  OP_WRITE: begin
                     cmd.mem_wr = 1'b1;
                     running_in = 1'b0;
                  end
                  OP_STOP: running_in = 1'b0;
                  OP_START: begin
                     if (status.count_ok) begin
                        running_in   = 1'b1;
                        cmd.load_e   = 1'b1;
                        cmd.use_zero = 1'b1;
                        state_in     = ST_CHECK;
                     end
                  end
                  default: begin
                     if (running_ff && status.count_ok) begin
                        cmd.load_e = 1'b1;
                        state_in   = ST_CHECK;
                     end
                  end
               endcase
            end
         end
         ST_CHECK: begin
            if (status.e_ge_d) begin
               cmd.rd_last = 1'b1;
               last_in     = 1'b1;
               state_in    = ST_EMIT;
            end else begin
               cmd.div_load = 1'b1;
               last_in      = 1'b0;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_RD0;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_RD0: begin
            cmd.rd_seg = 1'b1;
            state_in   = ST_RD1;
         end
         ST_RD1: begin
            cmd.rd_next = 1'b1;
            cmd.cap_p0  = 1'b1;
            lane_in     = LANE_LAT;
            state_in    = ST_MUL;
         end
         ST_MUL: begin
            cmd.lane_mul = 1'b1;
            state_in     = ST_ACC;
         end
         ST_ACC: begin
            cmd.lane_acc = 1'b1;
            if (lane_ff == LANE_HDG) begin
               state_in = ST_WRAP;
            end else begin
               lane_in  = lane_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_WRAP: begin
            if (status.wrap_done) begin
               state_in = ST_EMIT;
            end else begin
               cmd.wrap = 1'b1;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (last_ff) begin
                  running_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (csr_we) begin
         running_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         lane_ff    <= LANE_LAT;
         last_ff    <= 1'b0;
         running_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         lane_ff    <= lane_in;
         last_ff    <= last_in;
         running_ff <= running_in;
      end
   end

   a_final_stops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && status.out_free && last_ff) |=> !running_ff)
      else $error("running still set after the final point");

   a_idle_sample: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == OP_SAMPLE && !running_ff) |=> state_ff == ST_IDLE)
      else $error("sample started while not running");

endmodule

### sv/waypoint_route_interpolator.sv
// ---------------------------------------------------------------------------
// Waypoint route interpolator
// Writes, stops and configuration give no result. A sample past the duration
// returns the last waypoint; any other sample is interpolated through the
// bit-serial divider (one quotient bit per cycle, FRAC_BITS + 39 bits).
// One item is worked on at a time. Reset clears the running flag, sets the
// duration to 96000 and the count to zero; the route table is undefined
// until written.
// ---------------------------------------------------------------------------
module waypoint_route_interpolator import wri_pkg::*; #(
   parameter int FRAC_BITS     = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic [5:0]         req_waypoint_index,
   input  logic signed [30:0] req_lat_in,
   input  logic signed [31:0] req_lng_in,
   input  logic signed [23:0] req_alt_in,
   input  logic [15:0]        req_heading_in,
   input  logic [31:0]        req_elapsed_ms,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [30:0] rsp_lat_out,
   output logic signed [31:0] rsp_lng_out,
   output logic signed [23:0] rsp_alt_out,
   output logic [15:0]        rsp_heading_out,
   output logic               rsp_at_end,
   input  logic               csr_we,
   input  logic [0:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   cmd_type    cmd;
   status_type status;

   wri_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .csr_we     (csr_we),
      .status     (status),
      .cmd        (cmd)
   );

   wri_dp #(
      .FRAC_BITS     (FRAC_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_waypoint_index (req_waypoint_index),
      .req_lat_in         (req_lat_in),
      .req_lng_in         (req_lng_in),
      .req_alt_in         (req_alt_in),
      .req_heading_in     (req_heading_in),
      .req_elapsed_ms     (req_elapsed_ms),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .cmd                (cmd),
      .status             (status),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_lat_out        (rsp_lat_out),
      .rsp_lng_out        (rsp_lng_out),
      .rsp_alt_out        (rsp_alt_out),
      .rsp_heading_out    (rsp_heading_out),
      .rsp_at_end         (rsp_at_end)
   );

endmodule

### sim/tb_waypoint_route_interpolator.sv
// ---------------------------------------------------------------------------
// Waypoint route interpolator testbench
// Loads a route table, then starts and samples the route under several
// duration and waypoint count settings. A local route model predicts each
// interpolated point, and every returned point is checked field by field.
// ---------------------------------------------------------------------------
module tb_waypoint_route_interpolator;
   timeunit 1ns;
   timeprecision 1ps;
   import wri_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 100;

   typedef struct {
      logic signed [30:0] lat;
      logic signed [31:0] lng;
      logic signed [23:0] alt;
      logic        [15:0] hdg;
      logic               at_end;
   } route_point_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_opcode = OP_STOP;
   logic [5:0]         req_waypoint_index = '0;
   logic signed [30:0] req_lat_in = '0;
   logic signed [31:0] req_lng_in = '0;
   logic signed [23:0] req_alt_in = '0;
   logic [15:0]        req_heading_in = '0;
   logic [31:0]        req_elapsed_ms = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [30:0] rsp_lat_out;
   logic signed [31:0] rsp_lng_out;
   logic signed [23:0] rsp_alt_out;
   logic [15:0]        rsp_heading_out;
   logic               rsp_at_end;
   logic               csr_we = 1'b0;
   logic [0:0]         csr_index = REG_DURATION;
   logic [31:0]        csr_wdata = '0;

   // Local copy of the route state.
   logic signed [30:0] model_lat[64];
   logic signed [31:0] model_lng[64];
   logic signed [23:0] model_alt[64];
   logic [15:0]        model_hdg[64];
   bit                 model_running;
   bit [31:0]          model_duration = 96000;
   bit [6:0]           model_count;

   route_point_type    points_due[$];
   bit                 sender_gaps;
   bit                 receiver_stalls;
   int                 error_count;
   int                 points_checked;
   int                 end_points;
   int                 idle_cycles;

   always #5 clock = ~clock;

   waypoint_route_interpolator dut (.*);

   function automatic longint lerp_q(longint p0, longint p1, longint q);
      return p0 + (((p1 - p0) * q + 32768) >>> 16);
   endfunction

   function automatic bit predict_point(input bit [31:0] e, output route_point_type pt);
      longint unsigned n, segs, prod, seg, rem, q;
      longint h0, d, h;
      int i0, i1;
      n = (model_count > 64) ? 64 : model_count;
      if (!model_running || n < 2) return 0;
      if (e >= model_duration) begin
         pt.lat = model_lat[n - 1];
         pt.lng = model_lng[n - 1];
         pt.alt = model_alt[n - 1];
         pt.hdg = model_hdg[n - 1];
         pt.at_end = 1'b1;
         model_running = 0;
         return 1;
      end
      segs = n - 1;
      prod = longint'(e) * segs;
      seg = prod / model_duration;
      rem = prod % model_duration;
      if (seg >= segs) seg = segs - 1;
      q = (rem << 16) / model_duration;
      i0 = int'(seg);
      i1 = i0 + 1;
      h0 = longint'(model_hdg[i0]);
      d = longint'(model_hdg[i1]) - h0;
      if (d > HALF_TURN) d -= FULL_TURN;
      else if (d < -HALF_TURN) d += FULL_TURN;
      h = lerp_q(h0, h0 + d, q) % FULL_TURN;
      if (h < 0) h += FULL_TURN;
      pt.lat = 31'(lerp_q(model_lat[i0], model_lat[i1], q));
      pt.lng = 32'(lerp_q(model_lng[i0], model_lng[i1], q));
      pt.alt = 24'(lerp_q(model_alt[i0], model_alt[i1], q));
      pt.hdg = 16'(h);
      pt.at_end = 1'b0;
      return 1;
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [5:0] idx,
                            input logic [30:0] lat, input logic [31:0] lng,
                            input logic [23:0] alt, input logic [15:0] hdg,
                            input logic [31:0] e);
      route_point_type pt;
      if (sender_gaps && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_waypoint_index <= idx;
      req_lat_in <= lat;
      req_lng_in <= lng;
      req_alt_in <= alt;
      req_heading_in <= hdg;
      req_elapsed_ms <= e;
      do @(posedge clock); while (req_stall);
      case (op)
         OP_WRITE: begin
            model_running = 0;
            model_lat[idx] = lat;
            model_lng[idx] = lng;
            model_alt[idx] = alt;
            model_hdg[idx] = hdg;
         end
         OP_START: begin
            if (model_count >= 2) begin
               model_running = 1;
               if (predict_point(32'd0, pt)) points_due.push_back(pt);
            end
         end
         OP_STOP: model_running = 0;
         default: if (predict_point(e, pt)) points_due.push_back(pt);
      endcase
   endtask

   task automatic write_random_waypoint(input logic [5:0] idx);
      logic [15:0] hdg;
      hdg = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(35999));
      send_item(OP_WRITE, idx, 31'($urandom), $urandom, 24'($urandom), hdg, $urandom);
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (points_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_route_config(input bit [31:0] duration, input bit [6:0] count);
      wait_for_idle();
      csr_we <= 1'b1;
      csr_index <= REG_DURATION;
      csr_wdata <= duration;
      @(posedge clock);
      csr_index <= REG_COUNT;
      csr_wdata <= 32'(count);
      @(posedge clock);
      csr_we <= 1'b0;
      model_duration = duration;
      model_count = count;
      model_running = 0;
   endtask

   task automatic test_table_load();
      for (int i = 0; i < 64; i++) write_random_waypoint(6'(i));
   endtask

   task automatic test_directed();
      set_route_config(1000, 2);
      send_item(OP_WRITE, 0, 31'h3FFFFFFF, 32'h80000000, 24'h7FFFFF, 35000, 0);
      send_item(OP_WRITE, 1, 31'h40000000, 32'h7FFFFFFF, 24'h800000, 500, '1);
      send_item(OP_START, 0, 0, 0, 0, 0, '1);
      send_item(OP_SAMPLE, 0, 0, 0, 0, 0, 1);
      send_item(OP_SAMPLE, 0, 0, 0, 0, 0, 500);
      send_item(OP_SAMPLE, 0, 0, 0, 0, 0, 999);
      send_item(OP_SAMPLE, 0, 0, 0, 0, 0, 1000);
      send_item(OP_SAMPLE, 0, 0, 0, 0, 0, 7);
      send_item(OP_START, 0, 0, 0, 0, 0, 0);
      send_item(OP_STOP, 0, 0, 0, 0, 0, 0);
      send_item(OP_SAMPLE, 0, 0, 0, 0, 0, 5);
      send_item(OP_WRITE, 0, 0, 0, 0, 500, 0);
      send_item(OP_WRITE, 1, 0, 0, 0, 35000, 0);
      send_item(OP_START, 0, 0, 0, 0, 0, 0);
      send_item(OP_SAMPLE, 0, 0, 0, 0, 0, 250);
      send_item(OP_SAMPLE, 0, 0, 0, 0, 0, 32'hFFFFFFFF);
      send_item(OP_WRITE, 63, 31'h7FFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 16'hFFFF, 0);
      send_item(OP_WRITE, 0, 0, 0, 0, 16'hFFFF, 0);
      send_item(OP_START, 0, 0, 0, 0, 0, 0);
      send_item(OP_SAMPLE, 0, 0, 0, 0, 0, 600);
      set_route_config(1000, 1);
      send_item(OP_START, 0, 0, 0, 0, 0, 0);
      send_item(OP_SAMPLE, 0, 0, 0, 0, 0, 10);
      set_route_config(0, 127);
      send_item(OP_START, 0, 0, 0, 0, 0, 0);
      send_item(OP_SAMPLE, 0, 0, 0, 0, 0, 0);
   endtask

   task automatic test_random_phase(input bit [31:0] duration, input bit [6:0] count,
                                    input int items);
      longint span;
      int pick;
      set_route_config(duration, count);
      span = (longint'(duration) * 9) / 8;
      if (span > 64'hFFFFFFFF) span = 64'hFFFFFFFF;
      repeat (items) begin
         pick = $urandom_range(99);
         if (!model_running || pick < 6)
            send_item(OP_START, 0, 0, 0, 0, 0, $urandom);
         else if (pick < 9)
            send_item(OP_STOP, 0, 0, 0, 0, 0, $urandom);
         else if (pick < 12)
            write_random_waypoint(6'($urandom));
         else if (pick < 16)
            send_item(OP_SAMPLE, 0, 0, 0, 0, 0, $urandom);
         else
            send_item(OP_SAMPLE, 0, 0, 0, 0, 0, $urandom_range(0, 32'(span)));
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] expv,
                                input logic [31:0] actv);
      if (expv !== actv) begin
         $error("%s mismatch: expected %0h, got %0h", name, expv, actv);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      route_point_type pt;
      if (rsp_valid && !rsp_stall) begin
         if (points_due.size() == 0) begin
            $error("unexpected point transfer");
            error_count++;
         end else begin
            pt = points_due.pop_front();
            compare_field("lat_out", 32'(pt.lat), 32'(rsp_lat_out));
            compare_field("lng_out", pt.lng, rsp_lng_out);
            compare_field("alt_out", 32'(pt.alt), 32'(rsp_alt_out));
            compare_field("heading_out", 32'(pt.hdg), 32'(rsp_heading_out));
            compare_field("at_end", 32'(pt.at_end), 32'(rsp_at_end));
            points_checked++;
            if (pt.at_end) end_points++;
         end
      end
      rsp_stall <= receiver_stalls && ($urandom_range(99) < 13);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL waypoint_route_interpolator");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_table_load();
      test_directed();
      test_random_phase(96000, 64, 130);
      sender_gaps = 1;
      receiver_stalls = 1;
      test_random_phase(1, 2, 130);
      test_random_phase(7, 3, 130);
      test_random_phase(1000, 64, 130);
      test_random_phase(32'hFFFFFFFF, 64, 130);
      test_random_phase(0, 5, 60);
      repeat (6) test_random_phase($urandom_range(1, 200000), 7'($urandom_range(2, 64)), 130);
      test_random_phase($urandom, 127, 130);
      test_random_phase(1000, 1, 20);
      test_random_phase(5000, 0, 20);
      wait_for_idle();
      $display("Checked %0d interpolated points, %0d of them route ends,", points_checked,
               end_points);
      $display("over durations from zero to full range and counts from 0 to 127.");
      if (error_count == 0)
         $display("PASS waypoint_route_interpolator");
      else
         $display("FAIL waypoint_route_interpolator");
      $finish;
   end

endmodule
